/* rtl/core/csma_pkg.sv */
// Shared types and constants for the CSMA-CA backoff controller.
// No dependencies.
package csma_pkg;

    localparam int TICK_COUNTER_WIDTH_DEF = 16;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 16;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_BACKOFF  = 2'd1,
        PH_SAMPLING = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        FN_TX_REQ  = 2'd0,
        FN_CCA_REQ = 2'd1,
        FN_TICK    = 2'd2,
        FN_CANCEL  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        OC_CCA_REQ = 2'd0,
        OC_CLEAR   = 2'd1,
        OC_BUSY    = 2'd2,
        OC_CANCEL  = 2'd3
    } outcome_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_MIN_EXP  = 3'd0,
        REG_MAX_EXP  = 3'd1,
        REG_MAX_RTRY = 3'd2,
        REG_UNIT_SYM = 3'd3,
        REG_SAMP_SYM = 3'd4
    } reg_idx_t;

    typedef struct packed {
        outcome_t   outcome;
        logic [3:0] exponent_now;
        logic [3:0] retry_count;
        logic [1:0] state_now;
    } result_t;

endpackage

/* rtl/core/csma_ca_backoff_controller.sv */
// Unslotted CSMA-CA backoff controller, top level.
// Depends on csma_pkg.
// One transfer is taken per cycle while s_tready is high; its result, if any, is registered into
// the result register, or into the skid stage while the result register is stalled. s_tready
// falls only while both the result register and the skid stage hold results. Backoff delays are
// random units times unit_sym_reg, saturated to the tick counter width.
module csma_ca_backoff_controller
    import csma_pkg::*;
#(
    parameter int TICK_COUNTER_WIDTH = TICK_COUNTER_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // random_bits[7:0], phy_busy[8], channel_clear[9]
    input  logic [1:0]            s_tuser,   // func[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // state_now[1:0], retry_count[5:2], exponent_now[9:6]
    output logic [1:0]            m_tuser    // outcome[1:0]
);

    localparam int W    = TICK_COUNTER_WIDTH;
    localparam int WIDE = (W > 17) ? W : 17;
    localparam logic [WIDE-1:0] CNT_MAX = WIDE'((64'd1 << W) - 64'd1);

    logic [3:0]  min_exp_reg, max_exp_reg, max_rtry_reg;
    logic [7:0]  unit_sym_reg;
    logic [15:0] samp_sym_reg;

    phase_t      phase_reg, phase_next;
    logic [3:0]  retry_reg, retry_next;
    logic [3:0]  exp_reg, exp_next;
    logic [W-1:0] ticks_reg, ticks_next;

    result_t     out_reg, skid_reg, res_next;
    logic        out_valid_reg, skid_valid_reg;
    logic        has_res;

    func_t       func;
    logic [7:0]  rnd;
    logic        phy_busy, chan_clear;
    logic        accept, out_fire;

    logic [3:0]  busy_rtry;
    logic [4:0]  exp_inc;
    logic [3:0]  busy_exp;
    logic        busy_retry_ok;
    logic [3:0]  bo_exp;
    logic [7:0]  bo_mask;
    logic [8:0]  bo_units;
    logic [16:0] bo_prod;
    logic [WIDE-1:0] bo_wide, samp_wide;
    logic [W-1:0] bo_ticks, samp_ticks;

    assign func       = func_t'(s_tuser);
    assign rnd        = s_tdata[7:0];
    assign phy_busy   = s_tdata[8];
    assign chan_clear = s_tdata[9];

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_fire = out_valid_reg && m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.outcome;
    assign m_tdata  = {6'd0, out_reg.exponent_now, out_reg.retry_count, out_reg.state_now};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_exp_reg  <= 4'd3;
            max_exp_reg  <= 4'd5;
            max_rtry_reg <= 4'd4;
            unit_sym_reg <= 8'd20;
            samp_sym_reg <= 16'd8;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_MIN_EXP:  min_exp_reg  <= cfg_wdata[3:0];
                REG_MAX_EXP:  max_exp_reg  <= cfg_wdata[3:0];
                REG_MAX_RTRY: max_rtry_reg <= cfg_wdata[3:0];
                REG_UNIT_SYM: unit_sym_reg <= cfg_wdata[7:0];
                REG_SAMP_SYM: samp_sym_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // busy path: retry count, raised exponent
    assign busy_rtry     = (retry_reg == 4'd15) ? retry_reg : retry_reg + 4'd1;
    assign exp_inc       = {1'b0, exp_reg} + 5'd1;
    assign busy_exp      = (exp_inc < {1'b0, max_exp_reg}) ? exp_inc[3:0] : max_exp_reg;
    assign busy_retry_ok = busy_rtry < max_rtry_reg;

    // backoff length from the exponent in force when it starts
    assign bo_exp    = (func == FN_TX_REQ) ? min_exp_reg : busy_exp;
    assign bo_mask   = 8'((16'd1 << bo_exp) - 16'd1);
    assign bo_units  = 9'd1 + {1'b0, rnd & bo_mask};
    assign bo_prod   = {8'd0, bo_units} * {9'd0, unit_sym_reg};
    assign bo_wide   = WIDE'(bo_prod);
    assign samp_wide = WIDE'(samp_sym_reg);
    assign bo_ticks   = W'((bo_wide > CNT_MAX) ? CNT_MAX : bo_wide);
    assign samp_ticks = W'((samp_wide > CNT_MAX) ? CNT_MAX : samp_wide);

    always_comb begin
        phase_next       = phase_reg;
        retry_next       = retry_reg;
        exp_next         = exp_reg;
        ticks_next       = ticks_reg;
        has_res          = 1'b0;
        res_next.outcome = OC_CCA_REQ;
        case (func)
            FN_TX_REQ: begin
                if (phase_reg == PH_IDLE) begin
                    retry_next = 4'd0;
                    exp_next   = min_exp_reg;
                    ticks_next = bo_ticks;
                    phase_next = PH_BACKOFF;
                end
            end
            FN_CCA_REQ: begin
                if (phase_reg == PH_IDLE) begin
                    if (phy_busy) begin
                        retry_next = busy_rtry;
                        exp_next   = busy_exp;
                        if (busy_retry_ok) begin
                            ticks_next = bo_ticks;
                            phase_next = PH_BACKOFF;
                        end else begin
                            ticks_next       = '0;
                            phase_next       = PH_IDLE;
                            has_res          = 1'b1;
                            res_next.outcome = OC_BUSY;
                        end
                    end else begin
                        ticks_next = samp_ticks;
                        phase_next = PH_SAMPLING;
                    end
                end
            end
            FN_TICK: begin
                if (phase_reg != PH_IDLE) begin
                    if (ticks_reg > W'(1)) begin
                        ticks_next = ticks_reg - W'(1);
                    end else begin
                        ticks_next = '0;
                        if (phase_reg == PH_BACKOFF) begin
                            phase_next       = PH_IDLE;
                            has_res          = 1'b1;
                            res_next.outcome = OC_CCA_REQ;
                        end else if (chan_clear) begin
                            phase_next       = PH_IDLE;
                            has_res          = 1'b1;
                            res_next.outcome = OC_CLEAR;
                        end else begin
                            retry_next = busy_rtry;
                            exp_next   = busy_exp;
                            if (busy_retry_ok) begin
                                ticks_next = bo_ticks;
                                phase_next = PH_BACKOFF;
                            end else begin
                                phase_next       = PH_IDLE;
                                has_res          = 1'b1;
                                res_next.outcome = OC_BUSY;
                            end
                        end
                    end
                end
            end
            default: begin
                if (phase_reg != PH_IDLE) begin
                    phase_next       = PH_IDLE;
                    ticks_next       = '0;
                    has_res          = 1'b1;
                    res_next.outcome = OC_CANCEL;
                end
            end
        endcase
        res_next.state_now    = phase_next;
        res_next.retry_count  = retry_next;
        res_next.exponent_now = exp_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            retry_reg <= 4'd0;
            exp_reg   <= 4'd0;
            ticks_reg <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            retry_reg <= retry_next;
            exp_reg   <= exp_next;
            ticks_reg <= ticks_next;
        end
    end

    // result register with one skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_fire) begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (accept && has_res) begin
            if (!out_valid_reg || out_fire) begin
                out_reg       <= res_next;
                out_valid_reg <= 1'b1;
            end else begin
                skid_reg       <= res_next;
                skid_valid_reg <= 1'b1;
            end
        end else if (out_fire) begin
            out_valid_reg <= 1'b0;
        end
    end

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without a result in the output register");

    a_idle_no_ticks: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_IDLE) |-> (ticks_reg == '0))
        else $error("tick counter running while idle");

    a_stall_to_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && has_res && out_valid_reg && !m_tready) |=> skid_valid_reg)
        else $error("result lost while output stalled");

    a_retry_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && func != FN_TX_REQ) |=> (retry_reg >= $past(retry_reg)))
        else $error("retry count fell outside a transmit request");

endmodule
